>>> sv/sboh_pkg.sv
// ----------------------------------------------------------------------------
// sboh_pkg
// Shared constants, types and helpers of the soft-binned orientation
// histogram: widths, fixed-point angle constants and the bin-store control.
// ----------------------------------------------------------------------------
package sboh_pkg;

  // Histogram store geometry
  localparam int MAX_BINS  = 8;
  localparam int BIN_W     = $clog2(MAX_BINS);
  localparam int CNT_W     = $clog2(MAX_BINS + 1);
  localparam int ACC_WIDTH = 40;

  // Field widths
  localparam int ANGLE_W = 16;
  localparam int MAG_W   = 16;
  localparam int NBR_W   = 4;   // num_bins register

  // Angle scaled by bin count, one bin width equals FULL_TURN
  localparam int P_W     = ANGLE_W + CNT_W;
  localparam int DIF_W   = 15;  // half a bin at most
  localparam int Y_W     = DIF_W + 6;

  localparam logic [ANGLE_W-1:0] FULL_TURN = 16'd46080;
  localparam logic [P_W-1:0]     HALF_BIN  = P_W'(23040);

  // Shared multiplier
  localparam int MUL_W  = 22;
  localparam int PROD_W = 2 * MUL_W;

  // Reciprocal of 45 for floor(y / 45) with y below 2^21: ceil(2^27 / 45)
  localparam int RECIP_SH = 27;
  localparam logic [MUL_W-1:0] RECIP45 = 22'd2982617;

  // Control word from the sequencer to the bin store
  typedef struct packed {
    logic             add;
    logic             clr;
    logic [BIN_W-1:0] addr;
    logic [MAG_W-1:0] val;
  } acc_ctrl_t;

  // Number of bins in use, clamped to 2..MAX_BINS
  function automatic logic [CNT_W-1:0] bins_in_use(input logic [NBR_W-1:0] nb);
    logic [CNT_W-1:0] r;
    if (nb < NBR_W'(2)) begin
      r = CNT_W'(2);
    end else if (nb > NBR_W'(MAX_BINS)) begin
      r = CNT_W'(MAX_BINS);
    end else begin
      r = CNT_W'(nb);
    end
    return r;
  endfunction

endpackage

>>> sv/sboh_mul.sv
// ----------------------------------------------------------------------------
// sboh_mul
// Shared unsigned multiplier with a registered product. The sequencer steers
// its operands through the scaled angle, both reciprocal divisions, the bin
// centre and the magnitude split.
// ----------------------------------------------------------------------------
module sboh_mul
  import sboh_pkg::*;
(
  input  logic              clk_i,
  input  logic [MUL_W-1:0]  a_i,
  input  logic [MUL_W-1:0]  b_i,
  output logic [PROD_W-1:0] p_o
);

  logic [PROD_W-1:0] p_q;
  logic [PROD_W-1:0] p_d;

  assign p_d = PROD_W'(a_i) * PROD_W'(b_i);

  // product register, payload only
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

>>> sv/sboh_acc.sv
// ----------------------------------------------------------------------------
// sboh_acc
// Bin accumulator store: one saturating add or one read per cycle at the
// addressed bin, and a clear of every bin at once.
// ----------------------------------------------------------------------------
module sboh_acc
  import sboh_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  acc_ctrl_t            ctrl_i,
  output logic [ACC_WIDTH-1:0] rd_data_o
);

  logic [ACC_WIDTH-1:0] acc_q [MAX_BINS];
  logic [ACC_WIDTH:0]   sum;
  logic [ACC_WIDTH-1:0] sum_sat;

  assign rd_data_o = acc_q[ctrl_i.addr];

  // saturating add at the addressed bin
  assign sum     = {1'b0, rd_data_o} + (ACC_WIDTH + 1)'(ctrl_i.val);
  assign sum_sat = sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : sum[ACC_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_BINS; i++) begin
        acc_q[i] <= '0;
      end
    end else if (ctrl_i.clr) begin
      for (int i = 0; i < MAX_BINS; i++) begin
        acc_q[i] <= '0;
      end
    end else if (ctrl_i.add) begin
      acc_q[ctrl_i.addr] <= sum_sat;
    end
  end

endmodule

>>> sv/soft_binned_orientation_histogram.sv
// ----------------------------------------------------------------------------
// soft_binned_orientation_histogram
// Gradient orientation histogram with linear soft binning between the two
// nearest bins. Sequencer around one shared multiplier and the bin store.
//
//   channel  signals                                   direction
//   in       in_valid_i / in_stall_o, angle, mag, last  item in, one pixel
//   out      out_valid_o / out_stall_i, bin fields      item out, one bin
//   cfg      cfg_valid_i / cfg_ready_o, index, data     register write
//
// A pixel walks the states StIdle to StAdd2 in weighted mode; plain mode
// skips StWs, StSide and StAdd2. Five passes through the shared multiplier
// (three in plain mode) and two store updates (one in plain mode) are made.
// in_stall_o is high while a pixel is in work or bins leave. After a last
// pixel, one bin leaves per cycle while out_stall_i is low, then all bins
// clear. Reset clears the bins and the registers to 8 bins, weighted.
// ----------------------------------------------------------------------------
module soft_binned_orientation_histogram
  import sboh_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // pixel items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ANGLE_W-1:0]   angle_i,
  input  logic [MAG_W-1:0]     magnitude_i,
  input  logic                 last_pixel_i,
  // bin items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [BIN_W-1:0]     bin_index_o,
  output logic [ACC_WIDTH-1:0] bin_value_o,
  output logic                 last_bin_o,
  // register writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [3:0]           cfg_index_i,
  input  logic [3:0]           cfg_data_i
);

  localparam logic [3:0] CfgNumBins  = 4'd0;
  localparam logic [3:0] CfgWeighted = 4'd1;

  typedef enum logic [3:0] {
    StIdle, StBin, StCen, StDif, StWs, StSide, StAdd1, StAdd2, StEmit
  } state_e;

  state_e state_q, state_d;

  // registers
  logic [NBR_W-1:0] num_bins_q;
  logic             weighted_q;

  // per-pixel working values
  logic [MAG_W-1:0] mag_q, mag_d;
  logic             last_q, last_d;
  logic [P_W-1:0]   p_q, p_d;
  logic             lo_q, lo_d, hi_q, hi_d;
  logic [CNT_W-1:0] b_q, b_d;
  logic [BIN_W-1:0] bin_q, bin_d, nb_q, nb_d;
  logic [MAG_W-1:0] side_q, side_d;
  logic [BIN_W-1:0] emit_q, emit_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [BIN_W-1:0]     bin_index_q, bin_index_d;
  logic [ACC_WIDTH-1:0] bin_value_q, bin_value_d;
  logic                 last_bin_q, last_bin_d;

  // datapath
  logic [CNT_W-1:0]     n;
  logic [P_W-1:0]       full_n;
  logic [ANGLE_W-1:0]   ang_sat;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [PROD_W-1:0]    prod;
  logic [P_W-1:0]       p_now, centre, q_sum;
  logic [DIF_W-1:0]     dif;
  logic [Y_W-1:0]       y;
  logic [32:0]          rnd;
  logic [CNT_W-1:0]     b_inc;
  logic                 emit_last;
  logic                 out_load;
  acc_ctrl_t            acc_ctrl;
  logic [ACC_WIDTH-1:0] acc_rd;

  assign n       = bins_in_use(num_bins_q);
  assign full_n  = P_W'(n) * P_W'(FULL_TURN);
  assign ang_sat = (angle_i > FULL_TURN) ? FULL_TURN : angle_i;
  assign p_now   = prod[P_W-1:0];
  assign centre  = prod[P_W-1:0];
  assign q_sum   = p_now + HALF_BIN;
  assign b_inc   = b_q + CNT_W'(1);
  assign rnd     = prod[32:0] + 33'd32768;

  // configuration writes, taken at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bins_q <= NBR_W'(8);
      weighted_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgNumBins:  num_bins_q <= cfg_data_i;
        CfgWeighted: weighted_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // bin choice and distance to the bin centre
  always_comb begin
    bin_d = bin_q;
    nb_d  = nb_q;
    dif   = '0;
    if (lo_q) begin
      bin_d = '0;
      nb_d  = BIN_W'(1);
      dif   = p_q[DIF_W-1:0];
    end else if (hi_q) begin
      bin_d = '0;
      nb_d  = BIN_W'(n - CNT_W'(1));
      dif   = DIF_W'(full_n - p_q);
    end else begin
      bin_d = b_q[BIN_W-1:0];
      if (p_q >= centre) begin
        dif  = DIF_W'(p_q - centre);
        nb_d = (b_inc >= n) ? '0 : b_inc[BIN_W-1:0];
      end else begin
        dif  = DIF_W'(centre - p_q);
        nb_d = BIN_W'(b_q - CNT_W'(1));
      end
    end
  end

  // ws = floor((dif * 64 + 22) / 45) equals (dif * 2^16 + 23040) / 46080
  assign y = {dif, 6'd0} + Y_W'(22);

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      StIdle: begin
        mul_a = MUL_W'(ang_sat);
        mul_b = MUL_W'(n);
      end
      StBin: begin
        mul_a = MUL_W'(q_sum >> 10);
        mul_b = RECIP45;
      end
      StCen: begin
        mul_a = MUL_W'(prod[RECIP_SH +: CNT_W]);
        mul_b = MUL_W'(FULL_TURN);
      end
      StDif: begin
        mul_a = MUL_W'(y);
        mul_b = RECIP45;
      end
      StWs: begin
        mul_a = MUL_W'(mag_q);
        mul_b = MUL_W'(prod[RECIP_SH +: MAG_W]);
      end
      default: ;
    endcase
  end

  sboh_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // bin store control
  assign emit_last = ({1'b0, emit_q} == (n - CNT_W'(1)));
  assign out_load  = (state_q == StEmit) && (!out_valid_q || !out_stall_i);

  always_comb begin
    acc_ctrl      = '0;
    acc_ctrl.addr = bin_q;
    unique case (state_q)
      StAdd1: begin
        acc_ctrl.add  = 1'b1;
        acc_ctrl.addr = bin_q;
        acc_ctrl.val  = mag_q - side_q;
      end
      StAdd2: begin
        acc_ctrl.add  = 1'b1;
        acc_ctrl.addr = nb_q;
        acc_ctrl.val  = side_q;
      end
      StEmit: begin
        acc_ctrl.addr = emit_q;
        acc_ctrl.clr  = out_load && emit_last;
      end
      default: ;
    endcase
  end

  sboh_acc u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (acc_ctrl),
    .rd_data_o (acc_rd)
  );

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    last_d      = last_q;
    p_d         = p_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    b_d         = b_q;
    side_d      = side_q;
    emit_d      = emit_q;
    out_valid_d = out_valid_q && out_stall_i;
    bin_index_d = bin_index_q;
    bin_value_d = bin_value_q;
    last_bin_d  = last_bin_q;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          mag_d   = magnitude_i;
          last_d  = last_pixel_i;
          state_d = StBin;
        end
      end
      StBin: begin
        p_d     = p_now;
        lo_d    = (p_now <= HALF_BIN);
        hi_d    = (p_now >= full_n - HALF_BIN);
        state_d = StCen;
      end
      StCen: begin
        b_d     = prod[RECIP_SH +: CNT_W];
        state_d = StDif;
      end
      StDif: begin
        if (weighted_q) begin
          state_d = StWs;
        end else begin
          side_d  = '0;
          state_d = StAdd1;
        end
      end
      StWs: begin
        state_d = StSide;
      end
      StSide: begin
        side_d  = rnd[31:16];
        state_d = StAdd1;
      end
      StAdd1: begin
        if (weighted_q) begin
          state_d = StAdd2;
        end else begin
          state_d = last_q ? StEmit : StIdle;
        end
        emit_d = '0;
      end
      StAdd2: begin
        state_d = last_q ? StEmit : StIdle;
        emit_d  = '0;
      end
      StEmit: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          bin_index_d = emit_q;
          bin_value_d = acc_rd;
          last_bin_d  = emit_last;
          emit_d      = emit_q + BIN_W'(1);
          if (emit_last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      emit_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      emit_q      <= emit_d;
    end
  end

  // working values and output payload
  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    p_q         <= p_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    b_q         <= b_d;
    side_q      <= side_d;
    bin_index_q <= bin_index_d;
    bin_value_q <= bin_value_d;
    last_bin_q  <= last_bin_d;
    if (state_q == StDif) begin
      bin_q <= bin_d;
      nb_q  <= nb_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign bin_index_o = bin_index_q;
  assign bin_value_o = bin_value_q;
  assign last_bin_o  = last_bin_q;

endmodule
